@@ design/akr_pkg.sv @@
package akr_pkg;

    localparam int unsigned CountW = 31;
    localparam int unsigned RepW   = 4;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Speedup schedule: upper bounds of the first four stages.
    localparam logic [CountW-1:0] Stage1Max = CountW'(60);
    localparam logic [CountW-1:0] Stage2Max = CountW'(120);
    localparam logic [CountW-1:0] Stage3Max = CountW'(180);
    localparam logic [CountW-1:0] Stage4Max = CountW'(250);

    // Residue counters for the two periods that are not powers of two.
    localparam logic [3:0] SlowLast = 4'd13;
    localparam logic [3:0] FastLast = 4'd11;

    localparam logic [RepW-1:0] RepNone = RepW'(0);
    localparam logic [RepW-1:0] RepOne  = RepW'(1);
    localparam logic [RepW-1:0] RepBig  = RepW'(10);

    typedef struct packed {
        logic step;       // a beat is taken in this cycle
        logic is_event;   // button event word, otherwise a tick
        logic press;
        logic release_k;
        logic fast;
    } t_key_ctrl;

endpackage

@@ design/akr_key.sv @@
module akr_key (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  akr_pkg::t_key_ctrl           i_ctrl,
    output logic [akr_pkg::RepW-1:0]     o_repeat
);
    import akr_pkg::*;

    logic              r_held;
    logic [CountW-1:0] r_count;
    logic [3:0]        r_mod14;
    logic [3:0]        r_mod12;

    logic              n_held;
    logic [CountW-1:0] n_count;
    logic [3:0]        n_mod14;
    logic [3:0]        n_mod12;

    logic              sat;
    logic [CountW-1:0] cnt_inc;
    logic [3:0]        m14_inc;
    logic [3:0]        m12_inc;

    // The residues track the count modulo 14 and 12 and freeze with it at saturation.
    always_comb begin
        sat     = (r_count == CountMax);
        cnt_inc = sat ? r_count : r_count + CountW'(1);
        if (sat) begin
            m14_inc = r_mod14;
            m12_inc = r_mod12;
        end else begin
            m14_inc = (r_mod14 == SlowLast) ? 4'd0 : r_mod14 + 4'd1;
            m12_inc = (r_mod12 == FastLast) ? 4'd0 : r_mod12 + 4'd1;
        end
    end

    always_comb begin
        if (!r_held) begin
            o_repeat = RepNone;
        end else if (!i_ctrl.fast) begin
            o_repeat = (m14_inc == 4'd0) ? RepOne : RepNone;
        end else if (cnt_inc <= Stage1Max) begin
            o_repeat = (m12_inc == 4'd0) ? RepOne : RepNone;
        end else if (cnt_inc <= Stage2Max) begin
            o_repeat = (cnt_inc[2:0] == 3'd0) ? RepOne : RepNone;
        end else if (cnt_inc <= Stage3Max) begin
            o_repeat = (cnt_inc[1:0] == 2'd0) ? RepOne : RepNone;
        end else if (cnt_inc <= Stage4Max) begin
            o_repeat = RepOne;
        end else begin
            o_repeat = RepBig;
        end
    end

    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_mod14 = r_mod14;
        n_mod12 = r_mod12;
        if (i_ctrl.step) begin
            if (i_ctrl.is_event) begin
                // A release in the same word overrides the press.
                if (i_ctrl.press || i_ctrl.release_k) begin
                    n_held  = !i_ctrl.release_k;
                    n_count = '0;
                    n_mod14 = 4'd0;
                    n_mod12 = 4'd0;
                end
            end else if (r_held) begin
                n_count = cnt_inc;
                n_mod14 = m14_inc;
                n_mod12 = m12_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_count <= '0;
            r_mod14 <= 4'd0;
            r_mod12 <= 4'd0;
        end else begin
            r_held  <= n_held;
            r_count <= n_count;
            r_mod14 <= n_mod14;
            r_mod12 <= n_mod12;
        end
    end

`ifndef SYNTHESIS
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_count == '0))
        else $error("released key has a nonzero count");
    a_mod14_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod14 <= SlowLast)
        else $error("mod-14 residue out of range");
    a_mod12_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod12 <= FastLast)
        else $error("mod-12 residue out of range");
    a_zero_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_mod14 == 4'd0 && r_mod12 == 4'd0))
        else $error("residues disagree with a cleared count");
`endif

endmodule

@@ design/accelerating_key_repeat_top.sv @@
// The result of an accepted beat is registered and appears on the output in the next cycle.
// Throughput: one beat per cycle while the output is read; the key state updates at the
// accepting edge, so ticks and events may follow each other in consecutive cycles.
// The output register frees as it is read, so input ready follows output ready when full.
// Synchronous active-low reset releases both keys, clears their counters and empties the output.
module accelerating_key_repeat_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic                     i_up_push,
    input  logic                     i_up_lift,
    input  logic                     i_dn_push,
    input  logic                     i_dn_lift,
    input  logic                     i_speedup,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [akr_pkg::RepW-1:0] o_up_repeat,
    output logic [akr_pkg::RepW-1:0] o_down_repeat
);
    import akr_pkg::*;

    logic            accept;
    t_key_ctrl       up_ctrl;
    t_key_ctrl       down_ctrl;
    logic [RepW-1:0] up_rep;
    logic [RepW-1:0] down_rep;

    logic            r_out_valid;
    logic            n_out_valid;
    logic [RepW-1:0] r_up_rep;
    logic [RepW-1:0] r_down_rep;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        up_ctrl.step        = accept;
        up_ctrl.is_event    = i_action;
        up_ctrl.press       = i_up_push;
        up_ctrl.release_k   = i_up_lift;
        up_ctrl.fast        = i_speedup;
        down_ctrl.step      = accept;
        down_ctrl.is_event  = i_action;
        down_ctrl.press     = i_dn_push;
        down_ctrl.release_k = i_dn_lift;
        down_ctrl.fast      = i_speedup;
    end

    akr_key u_up (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (up_ctrl),
        .o_repeat (up_rep)
    );

    akr_key u_down (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (down_ctrl),
        .o_repeat (down_rep)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // An event word always reports no repeat for either key.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rep   <= i_action ? RepNone : up_rep;
            r_down_rep <= i_action ? RepNone : down_rep;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_up_repeat   = r_up_rep;
    assign o_down_repeat = r_down_rep;

`ifndef SYNTHESIS
    a_up_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_up_repeat == RepNone || o_up_repeat == RepOne
                         || o_up_repeat == RepBig))
        else $error("up repeat has an illegal value");
    a_down_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_down_repeat == RepNone || o_down_repeat == RepOne
                         || o_down_repeat == RepBig))
        else $error("down repeat has an illegal value");
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid))
        else $error("result beat without an input beat");
`endif

endmodule

@@ test/akr_checker.sv @@
module akr_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_action,
    input  logic                     i_up_push,
    input  logic                     i_up_lift,
    input  logic                     i_dn_push,
    input  logic                     i_dn_lift,
    input  logic                     i_speedup,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [akr_pkg::RepW-1:0] i_up_repeat,
    input  logic [akr_pkg::RepW-1:0] i_down_repeat,
    output int                       o_fail_count,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CntW = akr_pkg::CountW;
    localparam int unsigned RepW = akr_pkg::RepW;

    localparam logic [CntW-1:0] SlowPeriod  = CntW'(14);
    localparam logic [CntW-1:0] Fast1Period = CntW'(12);
    localparam logic [CntW-1:0] Fast2Period = CntW'(8);
    localparam logic [CntW-1:0] Fast3Period = CntW'(4);
    localparam logic [CntW-1:0] Fast1Limit  = CntW'(60);
    localparam logic [CntW-1:0] Fast2Limit  = CntW'(120);
    localparam logic [CntW-1:0] Fast3Limit  = CntW'(180);
    localparam logic [CntW-1:0] Fast4Limit  = CntW'(250);
    localparam logic [CntW-1:0] HoldMax     = {CntW{1'b1}};

    localparam logic [RepW-1:0] StepNone = RepW'(0);
    localparam logic [RepW-1:0] StepOne  = RepW'(1);
    localparam logic [RepW-1:0] StepTen  = RepW'(10);

    typedef struct packed {
        logic [RepW-1:0] up;
        logic [RepW-1:0] down;
    } t_repeat_pair;

    logic           up_is_held;
    logic [CntW-1:0] up_hold_ticks;
    logic           down_is_held;
    logic [CntW-1:0] down_hold_ticks;

    t_repeat_pair repeats_due[$];
    int           fail_total;
    int           due_total;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;

    initial begin
        fail_total = 0;
        due_total  = 0;
    end

    function automatic logic [RepW-1:0] step_for_hold(input logic [CntW-1:0] ticks,
                                                     input logic fast);
        if (!fast)
            return (ticks % SlowPeriod == '0) ? StepOne : StepNone;
        if (ticks <= Fast1Limit)
            return (ticks % Fast1Period == '0) ? StepOne : StepNone;
        if (ticks <= Fast2Limit)
            return (ticks % Fast2Period == '0) ? StepOne : StepNone;
        if (ticks <= Fast3Limit)
            return (ticks % Fast3Period == '0) ? StepOne : StepNone;
        if (ticks <= Fast4Limit)
            return StepOne;
        return StepTen;
    endfunction

    // Applies one beat to the key state and returns the repeat steps it produces.
    function automatic t_repeat_pair predict_repeats(input logic is_event, input logic up_p,
                                                     input logic up_r, input logic dn_p,
                                                     input logic dn_r, input logic fast);
        t_repeat_pair steps;
        steps = '{up: StepNone, down: StepNone};
        if (is_event) begin
            // Release is applied after press, so it wins when both are set.
            if (up_p) begin
                up_is_held    = 1'b1;
                up_hold_ticks = '0;
            end
            if (up_r) begin
                up_is_held    = 1'b0;
                up_hold_ticks = '0;
            end
            if (dn_p) begin
                down_is_held    = 1'b1;
                down_hold_ticks = '0;
            end
            if (dn_r) begin
                down_is_held    = 1'b0;
                down_hold_ticks = '0;
            end
        end else begin
            if (up_is_held) begin
                if (up_hold_ticks != HoldMax)
                    up_hold_ticks = up_hold_ticks + 1'b1;
                steps.up = step_for_hold(up_hold_ticks, fast);
            end
            if (down_is_held) begin
                if (down_hold_ticks != HoldMax)
                    down_hold_ticks = down_hold_ticks + 1'b1;
                steps.down = step_for_hold(down_hold_ticks, fast);
            end
        end
        return steps;
    endfunction

    always @(posedge i_clk) begin
        t_repeat_pair want;
        if (!i_rst_n) begin
            up_is_held      = 1'b0;
            up_hold_ticks   = '0;
            down_is_held    = 1'b0;
            down_hold_ticks = '0;
            repeats_due.delete();
        end else begin
            // Queue the new beat first so a same-edge result still finds its expectation.
            if (i_in_valid && i_in_ready)
                repeats_due.push_back(predict_repeats(i_action, i_up_push, i_up_lift,
                                                      i_dn_push, i_dn_lift,
                                                      i_speedup));
            if (i_out_valid && i_out_ready) begin
                if (repeats_due.size() == 0) begin
                    $error("unexpected result beat: up_repeat %0d, down_repeat %0d",
                           i_up_repeat, i_down_repeat);
                    fail_total++;
                end else begin
                    want = repeats_due.pop_front();
                    if (i_up_repeat !== want.up) begin
                        $error("up_repeat mismatch: expected %0d, actual %0d",
                               want.up, i_up_repeat);
                        fail_total++;
                    end
                    if (i_down_repeat !== want.down) begin
                        $error("down_repeat mismatch: expected %0d, actual %0d",
                               want.down, i_down_repeat);
                        fail_total++;
                    end
                end
            end
        end
        due_total = repeats_due.size();
    end

endmodule

@@ test/accelerating_key_repeat_top_tb.sv @@
module accelerating_key_repeat_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NumItems  = 950;
    localparam logic ActTick   = 1'b0;
    localparam logic ActEvent  = 1'b1;
    localparam int   HoldOff   = 80;

    typedef enum logic [1:0] {
        RxOpen,
        RxRandom,
        RxSparse
    } t_rx_mode;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     action;
    logic                     up_push;
    logic                     up_lift;
    logic                     dn_push;
    logic                     dn_lift;
    logic                     speedup;
    logic                     out_valid;
    logic                     out_ready;
    logic [akr_pkg::RepW-1:0] up_repeat;
    logic [akr_pkg::RepW-1:0] down_repeat;
    int                       fail_count;
    int                       pending;

    int burst_left;
    int beats_sent;

    accelerating_key_repeat_top u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_action       (action),
        .i_up_push      (up_push),
        .i_up_lift      (up_lift),
        .i_dn_push      (dn_push),
        .i_dn_lift      (dn_lift),
        .i_speedup      (speedup),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_up_repeat    (up_repeat),
        .o_down_repeat  (down_repeat)
    );

    akr_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (action),
        .i_up_push      (up_push),
        .i_up_lift      (up_lift),
        .i_dn_push      (dn_push),
        .i_dn_lift      (dn_lift),
        .i_speedup      (speedup),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_up_repeat    (up_repeat),
        .i_down_repeat  (down_repeat),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offers a beat at a falling edge; returns at one after it is taken and any idle gap.
    task automatic send_beat(input logic act, input logic up_p, input logic up_r,
                             input logic dn_p, input logic dn_r, input logic spd);
        int gap;
        in_valid = 1'b1;
        action   = act;
        up_push  = up_p;
        up_lift  = up_r;
        dn_push  = dn_p;
        dn_lift  = dn_r;
        speedup  = spd;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap      = $urandom_range(1, 8);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // The key fields of a tick and the speedup field of an event carry noise.
    task automatic send_tick(input logic spd);
        send_beat(ActTick, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), spd);
    endtask

    task automatic send_event(input logic up_p, input logic up_r, input logic dn_p,
                              input logic dn_r);
        send_beat(ActEvent, up_p, up_r, dn_p, dn_r, 1'($urandom));
    endtask

    initial begin
        out_ready = 1'b0;
    end

    // Receiver: changing stall patterns, plus long hold-offs so the input backs up.
    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        int       hold_left;
        int       cycle_no;
        rx_mode   = RxOpen;
        mode_left = 0;
        hold_left = 0;
        cycle_no  = 0;
        forever begin
            @(negedge clk);
            cycle_no++;
            if (cycle_no == 400 || cycle_no == 3000)
                hold_left = HoldOff;
            if (hold_left > 0) begin
                hold_left--;
                out_ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (rx_mode)
                    RxOpen:   out_ready = 1'b1;
                    RxRandom: out_ready = 1'($urandom);
                    default:  out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #2ms;
        $display("FAIL accelerating_key_repeat_top");
        $finish;
    end

    initial begin
        logic [1:0] keys;
        int         run_len;
        logic       fast_run;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ActTick;
        up_push    = 1'b0;
        up_lift    = 1'b0;
        dn_push    = 1'b0;
        dn_lift    = 1'b0;
        speedup    = 1'b0;
        burst_left = 0;
        beats_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: idle ticks, stray releases, the first fast repeat, press and release in
        // one word, the regular period, a restart on a held key, and all four key bits.
        send_tick(1'b0);
        send_tick(1'b1);
        send_event(1'b0, 1'b1, 1'b0, 1'b1);
        send_event(1'b1, 1'b0, 1'b1, 1'b0);
        repeat (12) send_tick(1'b1);
        send_event(1'b1, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_event(1'b0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b1);
        send_event(1'b1, 1'b1, 1'b1, 1'b1);
        send_tick(1'b1);
        send_event(1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(1'b0);

        // Random: mostly press, a run of ticks, then release; some raw noise in between.
        while (beats_sent < NumItems) begin
            if ($urandom_range(0, 99) < 75) begin
                keys = 2'($urandom_range(1, 3));
                send_event(keys[0], 1'b0, keys[1], 1'b0);
                run_len  = ($urandom_range(0, 2) == 0) ? $urandom_range(200, 320)
                                                       : $urandom_range(1, 60);
                fast_run = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < run_len && beats_sent < NumItems; i++) begin
                    if ($urandom_range(0, 149) == 0)
                        send_event(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                    else
                        send_tick(($urandom_range(0, 15) == 0) ? !fast_run : fast_run);
                end
                send_event(1'($urandom), ($urandom_range(0, 3) != 0), 1'($urandom),
                           ($urandom_range(0, 3) != 0));
            end else begin
                repeat ($urandom_range(1, 10))
                    send_beat(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom));
            end
        end
        in_valid = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS accelerating_key_repeat_top");
        end else begin
            $display("FAIL accelerating_key_repeat_top");
        end
        $finish;
    end

endmodule
